>>> hdl/fpp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types for the free page pool.
// No dependencies; every other file but fpp_ram imports this package.
package fpp_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int MAX_PAGES    = 32768;
   localparam int ADDR_W       = 32;
   localparam int OFFSET_W     = $clog2(PAGE_BYTES);
   localparam int PAGE_W       = ADDR_W - OFFSET_W;
   localparam int IDX_W        = $clog2(MAX_PAGES);
   localparam int COUNT_W      = $clog2(MAX_PAGES + 1);
   localparam int CURSOR_W     = PAGE_W + 1;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int FREE_COUNT_W = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_REGION_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_END   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INIT_WALK,
      S_ALLOC_WAIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                init_start;
      logic                init_step;
      logic                push;
      logic                pop;
      logic                rsp_load;
      logic                rsp_grant;
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic free_bad;
      logic init_done;
      logic rsp_busy;
   } dp_stat_type;

endpackage

>>> hdl/fpp_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses of the page pool.
// Depends on fpp_pkg for field widths.
interface fpp_req_if;
   import fpp_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   page_address;
   modport source (output valid, command, page_address, input ready);
   modport sink   (input valid, command, page_address, output ready);
endinterface

interface fpp_rsp_if;
   import fpp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ADDR_W-1:0]       granted_address;
   logic [STATUS_W-1:0]     status;
   logic [FREE_COUNT_W-1:0] free_count;
   modport source (output valid, granted_address, status, free_count, input ready);
   modport sink   (input valid, granted_address, status, free_count, output ready);
endinterface

>>> hdl/fpp_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> hdl/fpp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the page pool: decodes commands, sequences the
// init walk and the alloc read. Depends on fpp_pkg.
module fpp_ctrl
   import fpp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  dp_stat_type      stat,
   output dp_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // take a new item only when the response slot is free this cycle
            req_ready = !stat.rsp_busy;
            accept    = req_valid && req_ready;
            if (accept) begin
               unique case (req_command)
                  CMD_INIT: begin
                     cmd.init_start = 1'b1;
                     state_in       = S_INIT_WALK;
                  end
                  CMD_ALLOC: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_ALLOC_WAIT;
                     end
                  end
                  CMD_FREE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.free_bad) begin
                        cmd.rsp_status = STATUS_BAD;
                     end else if (stat.full) begin
                        cmd.rsp_status = STATUS_FULL;
                     end else begin
                        cmd.push       = 1'b1;
                        cmd.rsp_status = STATUS_OK;
                     end
                  end
                  default: begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STATUS_OK;
                  end
               endcase
            end
         end
         S_INIT_WALK: begin
            if (stat.init_done) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STATUS_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.init_step = 1'b1;
            end
         end
         S_ALLOC_WAIT: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_grant  = 1'b1;
            cmd.rsp_status = STATUS_OK;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/fpp_dp.sv
`timescale 1ns / 1ps
// Datapath of the page pool: region registers, stack depth, init cursor,
// stack RAM and response register. Depends on fpp_pkg and fpp_ram.
module fpp_dp
   import fpp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic [ADDR_W-1:0]       req_page_address,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [ADDR_W-1:0]       rsp_granted_address,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [FREE_COUNT_W-1:0] rsp_free_count,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat
);

   logic [ADDR_W-1:0]   region_start_ff;
   logic [ADDR_W-1:0]   region_end_ff;
   logic [COUNT_W-1:0]  depth_ff;
   logic [COUNT_W-1:0]  depth_in;
   logic [CURSOR_W-1:0] cursor_ff;
   logic [CURSOR_W-1:0] cursor_in;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [CURSOR_W-1:0] start_page;
   logic [CURSOR_W-1:0] end_page;
   logic [COUNT_W-1:0]  depth_dec;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [PAGE_W-1:0]   ram_wdata;
   logic [PAGE_W-1:0]   ram_rdata;

   // start rounded up to a whole page, end rounded down
   assign start_page = CURSOR_W'(region_start_ff[ADDR_W-1:OFFSET_W])
                     + CURSOR_W'(region_start_ff[OFFSET_W-1:0] != '0);
   assign end_page   = CURSOR_W'(region_end_ff[ADDR_W-1:OFFSET_W]);
   assign depth_dec  = depth_ff - COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_end_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_REGION_START: region_start_ff <= csr_write_data[ADDR_W-1:0];
            REG_REGION_END:   region_end_ff   <= csr_write_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      depth_in  = depth_ff;
      cursor_in = cursor_ff;
      if (cmd.init_start) begin
         depth_in  = '0;
         cursor_in = start_page;
      end else if (cmd.init_step) begin
         depth_in  = depth_ff + COUNT_W'(1);
         cursor_in = cursor_ff + CURSOR_W'(1);
      end else if (cmd.push) begin
         depth_in = depth_ff + COUNT_W'(1);
      end else if (cmd.pop) begin
         depth_in = depth_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         cursor_ff <= cursor_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_addr_ff   <= cmd.rsp_grant ? {ram_rdata, OFFSET_W'(0)} : '0;
      end
   end

   assign ram_we    = cmd.init_step || cmd.push;
   assign ram_waddr = depth_ff[IDX_W-1:0];
   assign ram_wdata = cmd.init_step ? cursor_ff[PAGE_W-1:0]
                                    : req_page_address[ADDR_W-1:OFFSET_W];

   fpp_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (MAX_PAGES)
   ) u_stack_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_enable   (cmd.pop),
      .read_address  (depth_dec[IDX_W-1:0]),
      .read_data     (ram_rdata)
   );

   assign stat.empty     = (depth_ff == '0);
   assign stat.full      = (depth_ff == COUNT_W'(MAX_PAGES));
   assign stat.free_bad  = (req_page_address[OFFSET_W-1:0] != '0)
                        || (req_page_address < region_start_ff)
                        || (req_page_address >= region_end_ff);
   assign stat.init_done = (cursor_ff >= end_page) || stat.full;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // depth moves on accepted items and init walk steps, never while stalled
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_count      = FREE_COUNT_W'(depth_ff);

endmodule

>>> hdl/free_page_pool_unit.sv
`timescale 1ns / 1ps
// Free page pool: LIFO stack of free physical pages held in one stack RAM.
// Free, no-op and failed alloc items respond in the cycle after the transfer;
// a granting alloc via the stack RAM read register, then the response register;
// init after its walk, which writes one page per cycle through the single RAM
// write port, then the response register. A new request is taken in the cycle
// the previous response transfers, or later. The user must write the region
// registers via the csr port only while the pool is idle; the block doesn't check.
module free_page_pool_unit
   import fpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fpp_req_if.sink               req_chan,
   fpp_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   fpp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   fpp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_page_address    (req_chan.page_address),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_granted_address (rsp_chan.granted_address),
      .rsp_status          (rsp_chan.status),
      .rsp_free_count      (rsp_chan.free_count),
      .cmd                 (cmd),
      .stat                (stat)
   );

   assign req_chan.ready = req_ready;

endmodule

>>> hdl/fpp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for free_page_pool_unit, attached with a bind.
// Depends on fpp_pkg and fpp_channels.
module fpp_checker
   import fpp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [ADDR_W-1:0]       rsp_granted_address,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [FREE_COUNT_W-1:0] rsp_free_count
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_address)
         && $stable(rsp_status) && $stable(rsp_free_count))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_error_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_address == '0)
      else $error("address granted with error status");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_free_count == '0)
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL
         |-> rsp_free_count == FREE_COUNT_W'(MAX_PAGES))
      else $error("full status with count below capacity");

endmodule

bind free_page_pool_unit fpp_checker u_fpp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_granted_address (rsp_chan.granted_address),
   .rsp_status          (rsp_chan.status),
   .rsp_free_count      (rsp_chan.free_count)
);
